FILE: hdl/tx_descriptor_ring_tracker_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the transmit descriptor ring tracker
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TX_DESCRIPTOR_RING_TRACKER_UNIT_ASSERT_SVH
`define TX_DESCRIPTOR_RING_TRACKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked while out of reset
`define TXDR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define TXDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TXDR_ASSERT(lbl, clk, rst_n, prop, msg)
`define TXDR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/txdr_pkg.sv
// ----------------------------------------------------------------------------
// txdr_pkg
// Types and constants shared by the transmit descriptor ring tracker.
// ----------------------------------------------------------------------------
package txdr_pkg;

    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 34;
    localparam int BCNT_W   = 11;
    localparam int REQ_W    = 16;
    localparam int SIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 11;

    localparam int DEF_RING_SLOTS = 16;
    localparam int DEF_PAGE_BYTES = 8192;

    // padding rules
    localparam int ALIGN_W = 5;
    localparam int PAD_MIN = 64;
    localparam int PAD_MAX = 2016;
    localparam int PAD_RND = 31;

    typedef enum logic [MODE_W-1:0] {
        MODE_SUBMIT_PKT  = 2'd0,
        MODE_SUBMIT_INIT = 2'd1,
        MODE_DEV_DONE    = 2'd2,
        MODE_SCAN        = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DONE     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_ACK      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_PKT  = 2'd1,
        KIND_INIT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUBMIT,
        S_ACK,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic              owned;
        t_kind             kind;
        logic [REQ_W-1:0]  request;
        logic              copied;
    } t_slot_entry;

endpackage

FILE: hdl/txdr_if.sv
// ----------------------------------------------------------------------------
// txdr request and response channels
// Valid/ready channels carrying the tracker's request and result fields.
// ----------------------------------------------------------------------------
interface txdr_req_if
    import txdr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] buf_address;
    logic [BCNT_W-1:0] byte_count;
    logic [REQ_W-1:0]  request_id;
    logic [SIDX_W-1:0] slot_index;

    modport source (output valid, mode, buf_address, byte_count, request_id, slot_index,
                    input ready);
    modport sink   (input valid, mode, buf_address, byte_count, request_id, slot_index,
                    output ready);
endinterface

interface txdr_rsp_if
    import txdr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SIDX_W-1:0]   slot;
    logic                copy_needed;
    logic [LEN_W-1:0]    padded_length;
    logic [REQ_W-1:0]    done_request;
    logic                last;

    modport source (output valid, status, slot, copy_needed, padded_length, done_request,
                    last, input ready);
    modport sink   (input valid, status, slot, copy_needed, padded_length, done_request,
                    last, output ready);
endinterface

FILE: hdl/tx_descriptor_ring_tracker_unit.sv
// ----------------------------------------------------------------------------
// tx_descriptor_ring_tracker_unit
// Transmit descriptor ring bookkeeping: slot allocation, device completion
// and completion scans, with per-slot state held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: submit packet, submit init block, device
//   finished a slot, or completion scan. o_rsp returns the results; the last
//   result of each request has last set. Both are valid/ready channels.
//   One request is worked at a time. Submit and device-done go from accept
//   to result through S_SUBMIT or S_ACK (device-done reads the slot on
//   accept; that state updates the slot RAM where it can and loads the
//   result). A completion scan reads the first slot on accept, then visits
//   one slot per RAM read (up to RING_SLOTS) and gives the final result
//   from S_FLUSH. A scan holds one result back so it can mark the final one.
//   Results go through an output register: when o_rsp stalls, work halts at
//   the next result and nothing is lost. A new request is taken once the
//   previous one has produced all its results into that register.
//   Reset (synchronous, active low) clears the indices, the in-flight count
//   and the per-slot valid bits; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
`include "tx_descriptor_ring_tracker_unit_assert.svh"

module tx_descriptor_ring_tracker_unit
    import txdr_pkg::*;
#(
    parameter int RING_SLOTS = DEF_RING_SLOTS,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    txdr_req_if.sink   i_req,
    txdr_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(RING_SLOTS);
    localparam int CNT_W = $clog2(RING_SLOTS + 1);
    localparam int ENT_W = $bits(t_slot_entry);

    // control state
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_insert, n_insert;
    logic [IDX_W-1:0]    r_oldest, n_oldest;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_start, n_start;
    logic                r_pend_valid, n_pend_valid;
    logic                r_out_valid;
    logic [RING_SLOTS-1:0] r_vld;
    logic                r_rd_vld;

    // request and pending payload
    t_mode               r_mode;
    logic [ADDR_W-1:0]   r_addr;
    logic [BCNT_W-1:0]   r_bcnt;
    logic [REQ_W-1:0]    r_reqid;
    logic [SIDX_W-1:0]   r_sidx;
    logic [IDX_W-1:0]    r_pend_slot, n_pend_slot;
    logic                r_pend_copy, n_pend_copy;
    logic [REQ_W-1:0]    r_pend_req, n_pend_req;

    // output register payload
    t_status             r_out_status;
    logic [SIDX_W-1:0]   r_out_slot;
    logic                r_out_copy;
    logic [LEN_W-1:0]    r_out_len;
    logic [REQ_W-1:0]    r_out_req;
    logic                r_out_last;

    // RAM port
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_slot_entry         ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENT_W-1:0]    ram_rdata;
    t_slot_entry         rd_ent;

    // result load
    logic                out_ok;
    logic                out_load;
    t_status             ld_status;
    logic [SIDX_W-1:0]   ld_slot;
    logic                ld_copy;
    logic [LEN_W-1:0]    ld_len;
    logic [REQ_W-1:0]    ld_req;
    logic                ld_last;

    // misc
    logic                req_fire;
    logic                calc_copy;
    logic [LEN_W-1:0]    calc_len;
    logic                rd_owned;
    t_kind               rd_kind;
    logic                freeing;
    logic                is_pkt;
    logic [CNT_W-1:0]    cnt_dec;
    logic [IDX_W-1:0]    idx_inc;
    logic                sidx_in_ring;

    txdr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RING_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    txdr_len_calc #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_len_calc (
        .i_buf_address   (r_addr),
        .i_byte_count    (r_bcnt),
        .o_copy_needed   (calc_copy),
        .o_padded_length (calc_len)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_ok      = !r_out_valid || o_rsp.ready;

    // a never-written slot reads as free and empty
    assign rd_ent   = t_slot_entry'(ram_rdata);
    assign rd_owned = r_rd_vld && rd_ent.owned;
    assign rd_kind  = r_rd_vld ? rd_ent.kind : KIND_NONE;
    assign freeing  = !rd_owned && (rd_kind != KIND_NONE);
    assign is_pkt   = freeing && (rd_kind == KIND_PKT);
    assign cnt_dec  = (r_count != '0) ? CNT_W'(r_count - 1'b1) : '0;
    assign idx_inc  = IDX_W'(r_idx + 1'b1);
    assign sidx_in_ring = ({1'b0, r_sidx} < (SIDX_W+1)'(RING_SLOTS));

    always_comb begin
        n_state      = r_state;
        n_insert     = r_insert;
        n_oldest     = r_oldest;
        n_count      = r_count;
        n_idx        = r_idx;
        n_start      = r_start;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_pend_copy  = r_pend_copy;
        n_pend_req   = r_pend_req;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = rd_ent;
        ram_re       = 1'b0;
        ram_raddr    = r_oldest;
        out_load     = 1'b0;
        ld_status    = ST_ACCEPTED;
        ld_slot      = '0;
        ld_copy      = 1'b0;
        ld_len       = '0;
        ld_req       = '0;
        ld_last      = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    case (t_mode'(i_req.mode))
                        MODE_DEV_DONE: begin
                            ram_re    = 1'b1;
                            ram_raddr = i_req.slot_index[IDX_W-1:0];
                            n_state   = S_ACK;
                        end
                        MODE_SCAN: begin
                            ram_re    = 1'b1;
                            ram_raddr = r_oldest;
                            n_idx     = r_oldest;
                            n_start   = r_oldest;
                            n_state   = S_SCAN;
                        end
                        default: begin
                            n_state = S_SUBMIT;
                        end
                    endcase
                end
            end

            S_SUBMIT: begin
                if (out_ok) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (r_count >= CNT_W'(RING_SLOTS)) begin
                        ld_status = ST_FULL;
                    end else begin
                        ram_we            = 1'b1;
                        ram_waddr         = r_insert;
                        ram_wdata.owned   = 1'b1;
                        ram_wdata.request = r_reqid;
                        n_insert          = IDX_W'(r_insert + 1'b1);
                        n_count           = CNT_W'(r_count + 1'b1);
                        ld_slot           = SIDX_W'(r_insert);
                        if (r_mode == MODE_SUBMIT_INIT) begin
                            ram_wdata.kind   = KIND_INIT;
                            ram_wdata.copied = 1'b0;
                        end else begin
                            ram_wdata.kind   = KIND_PKT;
                            ram_wdata.copied = calc_copy;
                            ld_copy          = calc_copy;
                            ld_len           = calc_len;
                        end
                    end
                end
            end

            S_ACK: begin
                if (out_ok) begin
                    out_load  = 1'b1;
                    ld_status = ST_ACK;
                    ld_slot   = r_sidx;
                    n_state   = S_IDLE;
                    if (sidx_in_ring) begin
                        ram_we          = 1'b1;
                        ram_waddr       = r_sidx[IDX_W-1:0];
                        ram_wdata.owned = 1'b0;
                        ram_wdata.kind  = rd_kind;
                    end
                end
            end

            S_SCAN: begin
                // a new packet completion must push the held one out first
                if (!(is_pkt && r_pend_valid && !out_ok)) begin
                    if (freeing) begin
                        ram_we          = 1'b1;
                        ram_waddr       = r_idx;
                        ram_wdata.owned = 1'b0;
                        ram_wdata.kind  = KIND_NONE;
                        n_count         = cnt_dec;
                        n_oldest        = idx_inc;
                    end
                    if (is_pkt) begin
                        if (r_pend_valid) begin
                            out_load  = 1'b1;
                            ld_status = ST_DONE;
                            ld_slot   = SIDX_W'(r_pend_slot);
                            ld_copy   = r_pend_copy;
                            ld_req    = r_pend_req;
                            ld_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_slot  = r_idx;
                        n_pend_copy  = rd_ent.copied;
                        n_pend_req   = rd_ent.request;
                    end
                    if (rd_owned || (freeing && cnt_dec == '0) || idx_inc == r_start) begin
                        n_state = S_FLUSH;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc;
                        n_idx     = idx_inc;
                    end
                end
            end

            S_FLUSH: begin
                if (out_ok) begin
                    out_load     = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                    if (r_pend_valid) begin
                        ld_status = ST_DONE;
                        ld_slot   = SIDX_W'(r_pend_slot);
                        ld_copy   = r_pend_copy;
                        ld_req    = r_pend_req;
                    end else begin
                        ld_status = ST_EMPTY;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_insert     <= '0;
            r_oldest     <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_start      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_vld        <= '0;
            r_rd_vld     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_insert     <= n_insert;
            r_oldest     <= n_oldest;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_start      <= n_start;
            r_pend_valid <= n_pend_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (ram_re) begin
                r_rd_vld <= r_vld[ram_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_mode  <= t_mode'(i_req.mode);
            r_addr  <= i_req.buf_address;
            r_bcnt  <= i_req.byte_count;
            r_reqid <= i_req.request_id;
            r_sidx  <= i_req.slot_index;
        end
        r_pend_slot <= n_pend_slot;
        r_pend_copy <= n_pend_copy;
        r_pend_req  <= n_pend_req;
        if (out_load) begin
            r_out_status <= ld_status;
            r_out_slot   <= ld_slot;
            r_out_copy   <= ld_copy;
            r_out_len    <= ld_len;
            r_out_req    <= ld_req;
            r_out_last   <= ld_last;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.slot          = r_out_slot;
    assign o_rsp.copy_needed   = r_out_copy;
    assign o_rsp.padded_length = r_out_len;
    assign o_rsp.done_request  = r_out_req;
    assign o_rsp.last          = r_out_last;

    `TXDR_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(RING_SLOTS), "in-flight count above ring size")
    `TXDR_ASSERT(a_rw_disjoint, i_clk, i_rst_n, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "RAM read and write hit the same slot")
    `TXDR_ASSERT(a_pend_scan, i_clk, i_rst_n, r_pend_valid |-> (r_state == S_SCAN || r_state == S_FLUSH), "held completion outside a scan")
    `TXDR_ASSERT(a_we_busy, i_clk, i_rst_n, ram_we |-> (r_state != S_IDLE), "slot RAM written while idle")

endmodule

FILE: hdl/txdr_ram.sv
// ----------------------------------------------------------------------------
// txdr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module txdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/txdr_len_calc.sv
// ----------------------------------------------------------------------------
// txdr_len_calc
// Bounce-copy decision and padded device length for a packet submission.
// ----------------------------------------------------------------------------
module txdr_len_calc
    import txdr_pkg::*;
#(
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic [ADDR_W-1:0] i_buf_address,
    input  logic [BCNT_W-1:0] i_byte_count,
    output logic              o_copy_needed,
    output logic [LEN_W-1:0]  o_padded_length
);

    localparam int PG_W = $clog2(PAGE_BYTES);

    logic [ADDR_W:0]  addr_x;
    logic [ADDR_W:0]  end_x;
    logic [LEN_W:0]   sum_rnd;
    logic [LEN_W:0]   rounded;

    assign addr_x = {1'b0, i_buf_address};
    // last byte address; may carry past the top address bit
    assign end_x  = (i_byte_count == '0) ? addr_x
                  : addr_x + (ADDR_W+1)'(i_byte_count) - (ADDR_W+1)'(1);

    assign o_copy_needed = (i_buf_address[ALIGN_W-1:0] != '0) ||
                           (addr_x[ADDR_W:PG_W] != end_x[ADDR_W:PG_W]);

    assign sum_rnd = {1'b0, i_byte_count} + (LEN_W+1)'(PAD_RND);
    assign rounded = {sum_rnd[LEN_W:ALIGN_W], {ALIGN_W{1'b0}}};

    always_comb begin
        if (i_byte_count < BCNT_W'(PAD_MIN)) begin
            o_padded_length = LEN_W'(PAD_MIN);
        end else if (rounded > (LEN_W+1)'(PAD_MAX)) begin
            o_padded_length = LEN_W'(PAD_MAX);
        end else begin
            o_padded_length = rounded[LEN_W-1:0];
        end
    end

endmodule
